// ----- rtl/esl_pkg.sv -----
// ----------------------------------------------------------------------------
// esl_pkg: shared types and constants of the signature list parser
// Request and result layouts, byte kinds, error codes and the X.509 type GUID.
// ----------------------------------------------------------------------------
package esl_pkg;

    // Byte kind doubles as the parser phase
    typedef enum logic [2:0] {
        PH_GUID  = 3'd0,
        PH_LSIZE = 3'd1,
        PH_HSIZE = 3'd2,
        PH_SSIZE = 3'd3,
        PH_HDR   = 3'd4,
        PH_OWNER = 3'd5,
        PH_DATA  = 3'd6,
        PH_IGN   = 3'd7
    } phase_t;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_HDR_LARGE  = 3'd1;
    localparam logic [2:0] ERR_SIG_ZERO   = 3'd2;
    localparam logic [2:0] ERR_LIST_SMALL = 3'd3;
    localparam logic [2:0] ERR_SIG_SMALL  = 3'd4;
    localparam logic [2:0] ERR_ODD        = 3'd5;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd6;
    localparam logic [2:0] ERR_TRUNC      = 3'd7;

    localparam int unsigned GUID_LEN  = 16;
    localparam int unsigned HDR_LEN   = GUID_LEN + 3 * 4;
    localparam int unsigned OWNER_LEN = 16;
    localparam int unsigned MAX_SIGS  = 16;
    localparam int unsigned DIV_BITS  = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  list_number;
        logic [3:0]  signature_number;
        logic [31:0] signature_offset;
        logic        type_is_x509;
        logic        signature_done;
        logic        list_done;
        logic [2:0]  error_code;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;

    function automatic logic [7:0] x509_guid_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'ha1;
            4'd1:    v = 8'h59;
            4'd2:    v = 8'hc0;
            4'd3:    v = 8'ha5;
            4'd4:    v = 8'he4;
            4'd5:    v = 8'h94;
            4'd6:    v = 8'ha7;
            4'd7:    v = 8'h4a;
            4'd8:    v = 8'h87;
            4'd9:    v = 8'hb5;
            4'd10:   v = 8'hab;
            4'd11:   v = 8'h15;
            4'd12:   v = 8'h5c;
            4'd13:   v = 8'h2b;
            4'd14:   v = 8'hf0;
            default: v = 8'h72;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/esl_div.sv -----
// ----------------------------------------------------------------------------
// esl_div: radix-2 restoring divider
// One quotient bit per cycle; result and done flag hold until the next start.
// ----------------------------------------------------------------------------
module esl_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic [31:0] remainder,
    output logic        done
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 6'(esl_pkg::DIV_BITS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so a non-negative trial fits 32 bits
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");

endmodule

// ----- rtl/esl_dpath.sv -----
// ----------------------------------------------------------------------------
// esl_dpath: parser datapath
// Holds the request, the list parse state and the result register; works out
// the tag of one byte and the next parse state when the controller steps it.
// ----------------------------------------------------------------------------
module esl_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  esl_pkg::cmd_t cmd,
    input  esl_pkg::req_t req,
    input  logic [31:0]   quotient,
    input  logic [31:0]   remainder,
    output logic          need_div,
    output logic [31:0]   dividend,
    output logic [31:0]   divisor,
    output esl_pkg::rsp_t rsp
);

    esl_pkg::req_t   in_reg;
    esl_pkg::rsp_t   out_reg, out_next;

    esl_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      fbc_reg, fbc_next;
    logic [31:0]     lsize_reg, lsize_next;
    logic [31:0]     hdr_size_reg, hdr_size_next;
    logic [31:0]     ssize_reg, ssize_next;
    logic [31:0]     left_reg, left_next;
    logic [31:0]     offset_reg, offset_next;
    logic [3:0]      sig_cnt_reg, sig_cnt_next;
    logic [7:0]      list_cnt_reg, list_cnt_next;
    logic            gm_reg, gm_next;
    logic [2:0]      err_reg, err_next;

    logic [7:0]      b;
    logic            fin;
    logic [3:0]      idx;
    logic [31:0]     lane;
    logic [31:0]     list_ins, hdr_ins, sig_ins;
    logic            e_hdr_large, e_sig_zero, e_list_small;
    logic [31:0]     payload_new, payload_cur;
    logic            at_check;
    logic [2:0]      check_err;

    assign b    = in_reg.data_byte;
    assign fin  = in_reg.final_byte;
    assign idx  = 4'(fbc_reg - 5'd16);
    assign lane = 32'(b) << {idx[1:0], 3'b000};

    // size registers as they stand once the current byte is merged in
    always_comb
    begin
        list_ins = lsize_reg;
        hdr_ins  = hdr_size_reg;
        sig_ins  = ssize_reg;
        if (fbc_reg == 5'd0)
        begin
            list_ins = '0;
            hdr_ins  = '0;
            sig_ins  = '0;
        end
        else if (fbc_reg >= 5'(esl_pkg::GUID_LEN))
        begin
            case (idx[3:2])
                2'd0:    list_ins = lsize_reg | lane;
                2'd1:    hdr_ins  = hdr_size_reg | lane;
                default: sig_ins  = ssize_reg | lane;
            endcase
        end
    end

    assign e_hdr_large  = (hdr_ins != 32'd0) && (hdr_ins >= list_ins);
    assign e_sig_zero   = (sig_ins == 32'd0);
    assign e_list_small = {1'b0, list_ins} < (33'(esl_pkg::HDR_LEN) + {1'b0, hdr_ins});
    assign payload_new  = list_ins - 32'(esl_pkg::HDR_LEN) - hdr_ins;
    assign payload_cur  = lsize_reg - 32'(esl_pkg::HDR_LEN) - hdr_size_reg;

    assign at_check = (phase_reg == esl_pkg::PH_SSIZE)
                   && (fbc_reg == 5'(esl_pkg::HDR_LEN - 1));
    assign need_div = at_check && !e_hdr_large && !e_sig_zero && !e_list_small;
    assign dividend = payload_new;
    assign divisor  = sig_ins;

    // quotient and remainder are only looked at when the divider has run
    always_comb
    begin
        if (e_hdr_large)
            check_err = esl_pkg::ERR_HDR_LARGE;
        else if (e_sig_zero)
            check_err = esl_pkg::ERR_SIG_ZERO;
        else if (e_list_small)
            check_err = esl_pkg::ERR_LIST_SMALL;
        else if (remainder != 32'd0)
            check_err = esl_pkg::ERR_ODD;
        else if ((payload_new != 32'd0) && (sig_ins < 32'(esl_pkg::OWNER_LEN)))
            check_err = esl_pkg::ERR_SIG_SMALL;
        else if (quotient > 32'(esl_pkg::MAX_SIGS))
            check_err = esl_pkg::ERR_TOO_MANY;
        else
            check_err = esl_pkg::ERR_NONE;
    end

    always_comb
    begin
        logic        eq;
        logic [4:0]  k1;
        logic        start_pl;
        logic [31:0] pl_val;
        logic        end_l;

        eq       = 1'b0;
        k1       = fbc_reg + 5'd1;
        start_pl = 1'b0;
        pl_val   = payload_cur;
        end_l    = 1'b0;

        phase_next     = phase_reg;
        fbc_next       = fbc_reg;
        lsize_next     = lsize_reg;
        hdr_size_next  = hdr_size_reg;
        ssize_next     = ssize_reg;
        left_next      = left_reg;
        offset_next    = offset_reg;
        sig_cnt_next   = sig_cnt_reg;
        list_cnt_next  = list_cnt_reg;
        gm_next        = gm_reg;
        err_next       = err_reg;

        out_next                  = '0;
        out_next.byte_kind        = esl_pkg::PH_IGN;
        out_next.list_number      = list_cnt_reg;

        case (phase_reg) inside
            esl_pkg::PH_GUID, esl_pkg::PH_LSIZE, esl_pkg::PH_HSIZE, esl_pkg::PH_SSIZE:
            begin
                out_next.byte_kind = phase_reg;
                if (fbc_reg < 5'(esl_pkg::GUID_LEN))
                begin
                    eq      = (b == esl_pkg::x509_guid_byte(fbc_reg[3:0]));
                    gm_next = (fbc_reg == 5'd0) ? eq : (gm_reg & eq);
                end
                lsize_next     = list_ins;
                hdr_size_next  = hdr_ins;
                ssize_next     = sig_ins;
                out_next.type_is_x509 = gm_next;
                fbc_next = k1;
                if (k1 == 5'(esl_pkg::GUID_LEN))
                    phase_next = esl_pkg::PH_LSIZE;
                else if (k1 == 5'(esl_pkg::GUID_LEN + 4))
                    phase_next = esl_pkg::PH_HSIZE;
                else if (k1 == 5'(esl_pkg::GUID_LEN + 8))
                    phase_next = esl_pkg::PH_SSIZE;
                else if (k1 == 5'(esl_pkg::HDR_LEN))
                begin
                    fbc_next = '0;
                    if (check_err != esl_pkg::ERR_NONE)
                    begin
                        err_next   = check_err;
                        phase_next = esl_pkg::PH_IGN;
                    end
                    else if (hdr_ins != 32'd0)
                    begin
                        phase_next = esl_pkg::PH_HDR;
                        left_next  = hdr_ins;
                    end
                    else
                    begin
                        start_pl = 1'b1;
                        pl_val   = payload_new;
                    end
                end
            end
            esl_pkg::PH_HDR:
            begin
                out_next.byte_kind    = esl_pkg::PH_HDR;
                out_next.type_is_x509 = gm_reg;
                left_next = left_reg - 32'd1;
                if (left_next == 32'd0)
                    start_pl = 1'b1;
            end
            esl_pkg::PH_OWNER, esl_pkg::PH_DATA:
            begin
                out_next.byte_kind        = phase_reg;
                out_next.type_is_x509     = gm_reg;
                out_next.signature_number = sig_cnt_reg;
                out_next.signature_offset = offset_reg;
                if (offset_reg == ssize_reg - 32'd1)
                begin
                    out_next.signature_done = 1'b1;
                    offset_next  = '0;
                    sig_cnt_next = sig_cnt_reg + 4'd1;
                end
                else
                    offset_next = offset_reg + 32'd1;
                left_next = left_reg - 32'd1;
                if (left_next == 32'd0)
                begin
                    out_next.list_done = 1'b1;
                    end_l = 1'b1;
                end
                else if (offset_next < 32'(esl_pkg::OWNER_LEN))
                    phase_next = esl_pkg::PH_OWNER;
                else
                    phase_next = esl_pkg::PH_DATA;
            end
            default:
            begin
                out_next.byte_kind = esl_pkg::PH_IGN;
            end
        endcase

        if (start_pl)
        begin
            if (pl_val == 32'd0)
            begin
                out_next.list_done = 1'b1;
                end_l = 1'b1;
            end
            else
            begin
                phase_next   = esl_pkg::PH_OWNER;
                left_next    = pl_val;
                offset_next  = '0;
                sig_cnt_next = '0;
            end
        end

        if (end_l)
        begin
            phase_next = esl_pkg::PH_GUID;
            fbc_next   = '0;
            if (list_cnt_reg != 8'hff)
                list_cnt_next = list_cnt_reg + 8'd1;
        end

        out_next.error_code = err_next;
        if (fin && (err_next == esl_pkg::ERR_NONE)
            && !((phase_next == esl_pkg::PH_GUID) && (fbc_next == 5'd0)))
            out_next.error_code = esl_pkg::ERR_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= esl_pkg::PH_GUID;
            fbc_reg       <= '0;
            lsize_reg     <= '0;
            hdr_size_reg  <= '0;
            ssize_reg     <= '0;
            left_reg      <= '0;
            offset_reg    <= '0;
            sig_cnt_reg   <= '0;
            list_cnt_reg  <= '0;
            gm_reg        <= 1'b1;
            err_reg       <= esl_pkg::ERR_NONE;
        end
        else if (cmd.step)
        begin
            if (fin)
            begin
                // end of database: back to the reset state
                phase_reg     <= esl_pkg::PH_GUID;
                fbc_reg       <= '0;
                lsize_reg     <= '0;
                hdr_size_reg  <= '0;
                ssize_reg     <= '0;
                left_reg      <= '0;
                offset_reg    <= '0;
                sig_cnt_reg   <= '0;
                list_cnt_reg  <= '0;
                gm_reg        <= 1'b1;
                err_reg       <= esl_pkg::ERR_NONE;
            end
            else
            begin
                phase_reg     <= phase_next;
                fbc_reg       <= fbc_next;
                lsize_reg     <= lsize_next;
                hdr_size_reg  <= hdr_size_next;
                ssize_reg     <= ssize_next;
                left_reg      <= left_next;
                offset_reg    <= offset_next;
                sig_cnt_reg   <= sig_cnt_next;
                list_cnt_reg  <= list_cnt_next;
                gm_reg        <= gm_next;
                err_reg       <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= req;
        if (cmd.step)
            out_reg <= out_next;
    end

    assign rsp = out_reg;

endmodule

// ----- rtl/esl_ctrl.sv -----
// ----------------------------------------------------------------------------
// esl_ctrl: parser controller
// Tracks the request and result slots, steps the datapath and runs the
// divider for the size check at the end of each list header.
// ----------------------------------------------------------------------------
module esl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          tag_valid,
    input  logic          tag_stall,
    input  esl_pkg::sts_t sts,
    output esl_pkg::cmd_t cmd
);

    typedef enum logic {
        CT_RUN,
        CT_DIV
    } state_t;

    state_t state_reg, state_next;
    logic   in_full_reg, in_full_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !tag_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load       = req_valid && !in_full_reg;
        unique case (state_reg)
            CT_RUN:
            begin
                if (in_full_reg)
                begin
                    if (sts.need_div)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = CT_DIV;
                    end
                    else if (out_free)
                        cmd.step = 1'b1;
                end
            end
            CT_DIV:
            begin
                if (sts.div_done && out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = CT_RUN;
                end
            end
            default:
            begin
                state_next = CT_RUN;
            end
        endcase

        in_full_next = in_full_reg;
        if (cmd.load)
            in_full_next = 1'b1;
        else if (cmd.step)
            in_full_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (!tag_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CT_RUN;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = in_full_reg;
    assign tag_valid = out_valid_reg;

    a_div_holds_req: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CT_DIV |-> in_full_reg)
        else $error("division running without a held request");

    a_step_needs_quot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && sts.need_div |-> state_reg == CT_DIV && sts.div_done)
        else $error("size check stepped before the divider finished");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg && !in_full_reg)
        else $error("stepped request not moved to the result slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tag_stall |-> !cmd.step)
        else $error("result overwritten while stalled");

endmodule

// ----- rtl/efi_signature_list_parser.sv -----
// ----------------------------------------------------------------------------
// efi_signature_list_parser: UEFI signature database byte tagger
//
//   channel  dir  handshake               payload
//   request  in   req_valid / req_stall   req (data_byte, final_byte)
//   tag      out  tag_valid / tag_stall   tag (kind, indexes, flags, error)
//
// A request is first taken into the input register, then tagged into the result register.
// The 28th byte of a list whose early size checks pass waits for the
// payload-by-signature-size check, which runs on a 1-bit-per-cycle divider.
// A result waits in its own register, so one more request is taken meanwhile.
// Reset (rst_n low, asynchronous) clears parse state and both slots; a
// request marked final returns the parse state to its reset values.
// ----------------------------------------------------------------------------
module efi_signature_list_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  esl_pkg::req_t req,
    output logic          tag_valid,
    input  logic          tag_stall,
    output esl_pkg::rsp_t tag
);

    esl_pkg::cmd_t cmd;
    esl_pkg::sts_t sts;
    logic          need_div;
    logic          div_done;
    logic [31:0]   dividend;
    logic [31:0]   divisor;
    logic [31:0]   quotient;
    logic [31:0]   remainder;

    assign sts.need_div = need_div;
    assign sts.div_done = div_done;

    esl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .tag_valid (tag_valid),
        .tag_stall (tag_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    esl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .quotient  (quotient),
        .remainder (remainder),
        .need_div  (need_div),
        .dividend  (dividend),
        .divisor   (divisor),
        .rsp       (tag)
    );

    esl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

endmodule
